/* sv/peq_pkg.sv */
`default_nettype none

package peq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int OUT_CNT_W   = 5;

   typedef enum logic [2:0] {
      OP_PUSH            = 3'd0,
      OP_POP             = 3'd1,
      OP_REMOVE_ID       = 3'd2,
      OP_REMOVE_HANDLE   = 3'd3,
      OP_REMOVE_RECEIVER = 3'd4,
      OP_FLUSH           = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   localparam logic CSR_NORMAL = 1'b0;
   localparam logic CSR_AGENT  = 1'b1;

   typedef struct packed {
      logic [15:0] handle;
      logic [15:0] id;
      logic [2:0]  prio;
      logic [31:0] receiver;
   } entry_type;

   typedef struct packed {
      op_type    op;
      entry_type item;
   } req_type;

   typedef struct packed {
      status_type           status;
      entry_type            popped;
      logic [OUT_CNT_W-1:0] removed;
      logic [OUT_CNT_W-1:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      entry_type        wr_data;
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [2:0]  normal_prio;
      logic [15:0] agent_id;
   } cfg_type;

endpackage

`default_nettype wire

/* sv/peq_store.sv */
`default_nettype none

module peq_store
   import peq_pkg::*;
(
   input  wire logic        clock,
   input  wire mem_req_type mem_req,
   output entry_type        rd_data
);

   entry_type mem_ff [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/peq_match.sv */
`default_nettype none

module peq_match
   import peq_pkg::*;
(
   input  wire op_type      op,
   input  wire entry_type   key,
   input  wire entry_type   stored,
   input  wire logic [15:0] agent_id,
   output logic             match,
   output logic             higher
);

   always_comb begin
      case (op)
         OP_REMOVE_ID: begin
            match = (stored.id == key.id);
         end
         OP_REMOVE_HANDLE: begin
            match = (stored.handle == key.handle);
         end
         OP_REMOVE_RECEIVER: begin
            match = (stored.id == agent_id) && (stored.receiver == key.receiver);
         end
         default: begin
            match = 1'b0;
         end
      endcase
   end

   assign higher = (key.prio > stored.prio);

endmodule

`default_nettype wire

/* sv/peq_seq.sv */
`default_nettype none

module peq_seq
   import peq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    req_valid,
   input  wire req_type req,
   output logic         req_stall,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp,
   output mem_req_type  mem_req,
   input  wire entry_type rd_data
);

   state_type            state_ff, state_in;
   op_type               op_ff, op_in;
   entry_type            key_ff, key_in;
   entry_type            carry_ff, carry_in;
   entry_type            popped_ff, popped_in;
   status_type           status_ff, status_in;
   logic                 inserted_ff, inserted_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic [CNT_W-1:0]     rdk_ff, rdk_in;
   logic [CNT_W-1:0]     w_ff, w_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]     rd_pos_ff, rd_pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 match;
   logic                 higher;
   logic                 rd_issue;
   logic                 scan_done;
   logic                 slot_free;
   logic                 drop;
   logic [CNT_W-1:0]     final_cnt;
   logic [CNT_W-1:0]     removed_cnt;

   peq_match u_match (
      .op       (op_ff),
      .key      (key_ff),
      .stored   (rd_data),
      .agent_id (cfg.agent_id),
      .match    (match),
      .higher   (higher)
   );

   assign rd_issue  = (state_ff == S_SCAN) && (rdk_ff < n_ff);
   assign scan_done = !rd_issue && !rd_valid_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign drop      = (op_ff == OP_POP) ? (rd_pos_ff == '0) : match;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      final_cnt   = cnt_ff;
      removed_cnt = '0;
      case (op_ff)
         OP_PUSH: begin
            if (status_ff == STATUS_OK) begin
               final_cnt = cnt_ff + CNT_W'(1);
            end
         end
         OP_POP: begin
            final_cnt = w_ff;
         end
         OP_REMOVE_ID, OP_REMOVE_HANDLE, OP_REMOVE_RECEIVER: begin
            final_cnt   = w_ff;
            removed_cnt = cnt_ff - w_ff;
         end
         OP_FLUSH: begin
            final_cnt   = '0;
            removed_cnt = cnt_ff;
         end
         default: begin
            final_cnt = cnt_ff;
         end
      endcase
   end

   always_comb begin
      op_in        = op_ff;
      key_in       = key_ff;
      carry_in     = carry_ff;
      popped_in    = popped_ff;
      status_in    = status_ff;
      inserted_in  = inserted_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      rdk_in       = rdk_ff;
      w_in         = w_ff;
      rd_valid_in  = rd_issue;
      rd_pos_in    = rdk_ff[IDX_W-1:0];
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      mem_req         = '0;
      mem_req.rd_en   = rd_issue;
      mem_req.rd_addr = rdk_ff[IDX_W-1:0];

      if (rd_issue) begin
         rdk_in = rdk_ff + CNT_W'(1);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in       = req.op;
               key_in      = req.item;
               rdk_in      = '0;
               w_in        = '0;
               n_in        = '0;
               inserted_in = 1'b0;
               popped_in   = '0;
               status_in   = STATUS_OK;
               case (req.op)
                  OP_PUSH: begin
                     if (cnt_ff == CNT_W'(QUEUE_DEPTH)) begin
                        status_in = STATUS_FULL;
                     end else if (req.item.prio != cfg.normal_prio) begin
                        n_in = cnt_ff;
                     end
                  end
                  OP_POP: begin
                     n_in = cnt_ff;
                     if (cnt_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end
                  end
                  OP_REMOVE_ID, OP_REMOVE_HANDLE, OP_REMOVE_RECEIVER: begin
                     n_in = cnt_ff;
                  end
                  default: begin
                     n_in = '0;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (rd_valid_ff) begin
               if (op_ff == OP_PUSH) begin
                  if (inserted_ff) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = rd_pos_ff;
                     mem_req.wr_data = carry_ff;
                     carry_in        = rd_data;
                  end else if (higher) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = rd_pos_ff;
                     mem_req.wr_data = key_ff;
                     carry_in        = rd_data;
                     inserted_in     = 1'b1;
                  end
               end else begin
                  if (!drop) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = w_ff[IDX_W-1:0];
                     mem_req.wr_data = rd_data;
                     w_in            = w_ff + CNT_W'(1);
                  end
                  if ((op_ff == OP_POP) && (rd_pos_ff == '0)) begin
                     popped_in = rd_data;
                  end
               end
            end
            if (scan_done && (op_ff == OP_PUSH) && (status_ff == STATUS_OK)) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = cnt_ff[IDX_W-1:0];
               mem_req.wr_data = inserted_ff ? carry_ff : key_ff;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = status_ff;
               rsp_in.popped    = popped_ff;
               rsp_in.removed   = OUT_CNT_W'(removed_cnt);
               rsp_in.occupancy = OUT_CNT_W'(final_cnt);
               cnt_in           = final_cnt;
            end
         end
         default: begin
            rd_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      carry_ff    <= carry_in;
      popped_ff   <= popped_in;
      status_ff   <= status_in;
      inserted_ff <= inserted_in;
      n_ff        <= n_in;
      rdk_ff      <= rdk_in;
      w_ff        <= w_in;
      rd_pos_ff   <= rd_pos_in;
      rsp_ff      <= rsp_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("entry count exceeds queue depth");

   a_write_behind_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && rd_valid_ff && op_ff != OP_PUSH) |-> (w_ff <= CNT_W'(rd_pos_ff)))
      else $error("compaction write pointer overtook the read position");

   a_scan_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |-> (!rd_valid_ff && rdk_ff == n_ff))
      else $error("scan finished with reads outstanding");

   a_push_full_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE && op_ff == OP_PUSH && status_ff == STATUS_FULL) |-> !mem_req.wr_en)
      else $error("rejected request wrote the entry store");

endmodule

`default_nettype wire

/* sv/priority_event_queue_top.sv */
// The sequencer reads through all stored entries in the entry store for pop, the remove
// operations and a push at a non-normal priority into a queue that is not full; otherwise it
// reads none. A new request is accepted only after the previous one has finished and its
// response has been registered, so it also waits while a finished response is held behind a
// stalled earlier one.
// Reset is synchronous and active high; it empties the queue, clears both registers, not the store.
`default_nettype none

module priority_event_queue_top
   import peq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_operation,
   input  wire logic [15:0] req_event_handle,
   input  wire logic [15:0] req_event_id,
   input  wire logic [2:0]  req_event_priority,
   input  wire logic [31:0] req_receiver_tag,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_out_handle,
   output logic [15:0]      rsp_out_event_id,
   output logic [2:0]       rsp_out_priority,
   output logic [31:0]      rsp_out_receiver,
   output logic [4:0]       rsp_removed_count,
   output logic [4:0]       rsp_occupancy
);

   logic [2:0]  normal_prio_ff, normal_prio_in;
   logic [15:0] agent_id_ff, agent_id_in;
   logic        csr_write;
   cfg_type     cfg;
   req_type     req;
   rsp_type     rsp;
   mem_req_type mem_req;
   entry_type   rd_data;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      normal_prio_in = normal_prio_ff;
      agent_id_in    = agent_id_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_NORMAL: begin
               normal_prio_in = pwdata[2:0];
            end
            CSR_AGENT: begin
               agent_id_in = pwdata[15:0];
            end
            default: begin
               normal_prio_in = normal_prio_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         CSR_NORMAL: begin
            prdata = {29'd0, normal_prio_ff};
         end
         CSR_AGENT: begin
            prdata = {16'd0, agent_id_ff};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_prio_ff <= '0;
         agent_id_ff    <= '0;
      end else begin
         normal_prio_ff <= normal_prio_in;
         agent_id_ff    <= agent_id_in;
      end
   end

   assign cfg.normal_prio = normal_prio_ff;
   assign cfg.agent_id    = agent_id_ff;

   assign req.op            = op_type'(req_operation);
   assign req.item.handle   = req_event_handle;
   assign req.item.id       = req_event_id;
   assign req.item.prio     = req_event_priority;
   assign req.item.receiver = req_receiver_tag;

   peq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req       (req),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   peq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign rsp_status        = rsp.status;
   assign rsp_out_handle    = rsp.popped.handle;
   assign rsp_out_event_id  = rsp.popped.id;
   assign rsp_out_priority  = rsp.popped.prio;
   assign rsp_out_receiver  = rsp.popped.receiver;
   assign rsp_removed_count = rsp.removed;
   assign rsp_occupancy     = rsp.occupancy;

endmodule

`default_nettype wire
